FILE: design/sltbl_pkg.sv
// Package for the sequential list table: widths, operation codes, cell commands and FSM states.
`default_nettype none
package sltbl_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int VALUE_W      = 32;
   localparam int OP_W         = 3;
   localparam int RSP_POS_W    = 7;
   localparam int RSP_CNT_W    = 7;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND    = 3'd0,
      OP_PREPEND   = 3'd1,
      OP_DROP_TAIL = 3'd2,
      OP_DROP_HEAD = 3'd3,
      OP_SORTED    = 3'd4,
      OP_REMOVE    = 3'd5,
      OP_SEARCH    = 3'd6
   } op_type;

   // What one cell does with its entry in the apply cycle.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_BELOW,
      CELL_FROM_ABOVE
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   // Compare result that a cell reports to the controller.
   typedef struct packed {
      logic eq;
      logic lt;
   } cell_flags_type;

endpackage
`default_nettype wire

FILE: design/sltbl_cell.sv
// One list cell: holds a single entry, compares it and shifts with its neighbors.
`default_nettype none
module sltbl_cell (
   input  wire                                    clock,
   input  wire                                    cmp_en,
   input  wire logic signed [sltbl_pkg::VALUE_W-1:0] cmp_value,
   input  wire                                    shift_en,
   input  wire sltbl_pkg::cell_cmd_type           cmd,
   input  wire logic signed [sltbl_pkg::VALUE_W-1:0] load_value,
   input  wire logic signed [sltbl_pkg::VALUE_W-1:0] below_entry,
   input  wire logic signed [sltbl_pkg::VALUE_W-1:0] above_entry,
   output logic signed [sltbl_pkg::VALUE_W-1:0]   entry,
   output sltbl_pkg::cell_flags_type              flags
);
   import sltbl_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff;
   cell_flags_type            flags_ff;
   cell_flags_type            flags_in;

   always_comb begin
      flags_in.eq = (entry_ff == cmp_value);
      flags_in.lt = (entry_ff < cmp_value);
   end

   always_ff @(posedge clock) begin
      if (cmp_en) begin
         flags_ff <= flags_in;
      end
      if (shift_en) begin
         unique case (cmd)
            CELL_HOLD:       entry_ff <= entry_ff;
            CELL_LOAD:       entry_ff <= load_value;
            CELL_FROM_BELOW: entry_ff <= below_entry;
            CELL_FROM_ABOVE: entry_ff <= above_entry;
            default:         entry_ff <= entry_ff;
         endcase
      end
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule
`default_nettype wire

FILE: design/sltbl_ctrl.sv
// Controller: sequencing, fill count, per-cell shift commands and result registers.
`default_nettype none
module sltbl_ctrl #(
   parameter int CAPACITY = sltbl_pkg::CAPACITY_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   input  wire logic [sltbl_pkg::OP_W-1:0]       req_operation,
   input  wire sltbl_pkg::cell_flags_type        flags [CAPACITY],
   output logic                                  busy,
   output logic                                  cmp_en,
   output logic                                  shift_en,
   output sltbl_pkg::cell_cmd_type               cell_cmd [CAPACITY],
   output logic                                  rsp_strobe,
   output logic                                  rsp_success,
   output logic signed [sltbl_pkg::RSP_POS_W-1:0] rsp_position,
   output logic [sltbl_pkg::RSP_CNT_W-1:0]       rsp_count,
   output logic                                  rsp_is_full,
   output logic                                  rsp_is_empty
);
   import sltbl_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CAPACITY-1:0] ONE_V = CAPACITY'(1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   cell_cmd_type         cmd_ff [CAPACITY];
   cell_cmd_type         cmd_in [CAPACITY];
   logic                 strobe_ff;
   logic                 success_ff, success_in;
   logic signed [RSP_POS_W-1:0] position_ff, position_in;
   logic [RSP_CNT_W-1:0] rcount_ff;
   logic                 full_ff, empty_ff;

   logic                 scan_en;
   logic [CAPACITY-1:0]  validv, eqv, stopv;
   logic [CAPACITY-1:0]  first_eq, ge_eq, first_stop, ge_stop;
   logic                 found, full, empty;
   logic [IDX_W-1:0]     match_idx;
   logic [IDX_W+RSP_POS_W-1:0] pos_ext;
   logic [CNT_W+RSP_CNT_W-1:0] cnt_ext;

   // Next state.
   always_comb begin
      unique case (state_ff)
         ST_IDLE:  state_in = start ? ST_SCAN : ST_IDLE;
         ST_SCAN:  state_in = ST_APPLY;
         ST_APPLY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State decode.
   always_comb begin
      busy     = 1'b1;
      cmp_en   = 1'b0;
      scan_en  = 1'b0;
      shift_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy   = 1'b0;
            cmp_en = start;
         end
         ST_SCAN:  scan_en = 1'b1;
         ST_APPLY: shift_en = 1'b1;
         default:  busy = 1'b1;
      endcase
   end

   // Flag vectors and the lowest set bit of each, found with one subtract.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         validv[i] = (CNT_W'(i) < count_ff);
         eqv[i]    = flags[i].eq & validv[i];
         stopv[i]  = ~(flags[i].lt & validv[i]);
      end
      first_eq   = eqv & (~eqv + ONE_V);
      ge_eq      = ~(first_eq - ONE_V);
      first_stop = stopv & (~stopv + ONE_V);
      ge_stop    = ~(first_stop - ONE_V);
      found      = |eqv;
      full       = (count_ff == CAP_CNT);
      empty      = (count_ff == '0);
      match_idx  = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_eq[i]) begin
            match_idx = match_idx | IDX_W'(i);
         end
      end
   end

   // Per-cell commands and the result of the operation.
   always_comb begin
      count_in   = count_ff;
      success_in = 1'b0;
      pos_ext    = {{RSP_POS_W{1'b0}}, match_idx};
      for (int i = 0; i < CAPACITY; i++) begin
         cmd_in[i] = CELL_HOLD;
      end
      unique case (op_ff)
         OP_APPEND: begin
            if (!full) begin
               count_in   = count_ff + CNT_W'(1);
               success_in = 1'b1;
               for (int i = 0; i < CAPACITY; i++) begin
                  if (CNT_W'(i) == count_ff) cmd_in[i] = CELL_LOAD;
               end
            end
         end
         OP_PREPEND: begin
            if (!full) begin
               count_in   = count_ff + CNT_W'(1);
               success_in = 1'b1;
               for (int i = 0; i < CAPACITY; i++) begin
                  cmd_in[i] = (i == 0) ? CELL_LOAD : CELL_FROM_BELOW;
               end
            end
         end
         OP_DROP_TAIL: begin
            if (!empty) begin
               count_in   = count_ff - CNT_W'(1);
               success_in = 1'b1;
            end
         end
         OP_DROP_HEAD: begin
            if (!empty) begin
               count_in   = count_ff - CNT_W'(1);
               success_in = 1'b1;
               for (int i = 0; i < CAPACITY; i++) begin
                  cmd_in[i] = CELL_FROM_ABOVE;
               end
            end
         end
         OP_SORTED: begin
            if (!full) begin
               count_in   = count_ff + CNT_W'(1);
               success_in = 1'b1;
               for (int i = 0; i < CAPACITY; i++) begin
                  if (first_stop[i]) begin
                     cmd_in[i] = CELL_LOAD;
                  end else if (ge_stop[i]) begin
                     cmd_in[i] = CELL_FROM_BELOW;
                  end
               end
            end
         end
         OP_REMOVE: begin
            if (found) begin
               count_in   = count_ff - CNT_W'(1);
               success_in = 1'b1;
               for (int i = 0; i < CAPACITY; i++) begin
                  if (ge_eq[i]) cmd_in[i] = CELL_FROM_ABOVE;
               end
            end
         end
         OP_SEARCH: success_in = found;
         default:   success_in = 1'b0;
      endcase
      if ((op_ff == OP_REMOVE || op_ff == OP_SEARCH) && found) begin
         position_in = pos_ext[RSP_POS_W-1:0];
      end else begin
         position_in = '1;
      end
      cnt_ext = {{RSP_CNT_W{1'b0}}, count_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= shift_en;
         if (scan_en) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_en) begin
         op_ff <= req_operation;
      end
      if (scan_en) begin
         cmd_ff      <= cmd_in;
         success_ff  <= success_in;
         position_ff <= position_in;
         rcount_ff   <= cnt_ext[RSP_CNT_W-1:0];
         full_ff     <= (count_in == CAP_CNT);
         empty_ff    <= (count_in == '0);
      end
   end

   assign cell_cmd     = cmd_ff;
   assign rsp_strobe   = strobe_ff;
   assign rsp_success  = success_ff;
   assign rsp_position = position_ff;
   assign rsp_count    = rcount_ff;
   assign rsp_is_full  = full_ff;
   assign rsp_is_empty = empty_ff;

endmodule
`default_nettype wire

FILE: design/sequential_list_table.sv
// An accepted request gives its result beat (rsp_strobe) at the end of its scan and apply steps.
// busy is high after acceptance until the apply step ends, so a new request is taken only once
// the last one is through the compare, scan and shift steps (scan in the controller).
// The receiver cannot stall: rsp_strobe is high for exactly one cycle per result beat.
// Reset (synchronous, active high) empties the list and clears the sequencer; entry
// storage is not cleared, since only entries below the fill count are ever read.
`default_nettype none
module sequential_list_table #(
   parameter int CAPACITY = sltbl_pkg::CAPACITY_DEF
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       start,
   output logic                                      busy,
   input  wire logic [sltbl_pkg::OP_W-1:0]           req_operation,
   input  wire logic signed [sltbl_pkg::VALUE_W-1:0] req_value,
   output logic                                      rsp_strobe,
   output logic                                      rsp_success,
   output logic signed [sltbl_pkg::RSP_POS_W-1:0]    rsp_position,
   output logic [sltbl_pkg::RSP_CNT_W-1:0]           rsp_count,
   output logic                                      rsp_is_full,
   output logic                                      rsp_is_empty
);
   import sltbl_pkg::*;

   // The list is a row of cells, entry 0 at the head. On the accepting edge every cell
   // compares its entry with the request value. In the scan cycle the controller turns
   // those flags into one command per cell, and on the apply edge every cell loads the
   // request value, takes its lower or upper neighbor's entry, or holds.

   logic                      cmp_en;
   logic                      shift_en;
   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] entries [CAPACITY];
   cell_flags_type            flags [CAPACITY];
   cell_cmd_type              cell_cmd [CAPACITY];

   // The request value is kept for the apply edge, where one cell loads it.
   always_ff @(posedge clock) begin
      if (cmp_en) begin
         value_ff <= req_value;
      end
   end

   sltbl_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .flags         (flags),
      .busy          (busy),
      .cmp_en        (cmp_en),
      .shift_en      (shift_en),
      .cell_cmd      (cell_cmd),
      .rsp_strobe    (rsp_strobe),
      .rsp_success   (rsp_success),
      .rsp_position  (rsp_position),
      .rsp_count     (rsp_count),
      .rsp_is_full   (rsp_is_full),
      .rsp_is_empty  (rsp_is_empty)
   );

   // The head cell has no lower neighbor and the last cell holds its own entry when
   // asked to take from above; in both cases the entry lies outside the live list.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_W-1:0] below;
      logic signed [VALUE_W-1:0] above;

      if (g == 0) begin : g_head
         assign below = '0;
      end else begin : g_mid_lo
         assign below = entries[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign above = entries[g];
      end else begin : g_mid_hi
         assign above = entries[g+1];
      end

      sltbl_cell u_cell (
         .clock       (clock),
         .cmp_en      (cmp_en),
         .cmp_value   (req_value),
         .shift_en    (shift_en),
         .cmd         (cell_cmd[g]),
         .load_value  (value_ff),
         .below_entry (below),
         .above_entry (above),
         .entry       (entries[g]),
         .flags       (flags[g])
      );
   end

endmodule
`default_nettype wire
